@@ rtl/crfp_pkg.sv @@
// Shared types and constants for the chiller response frame parser.
// No dependencies; imported by chiller_response_frame_parser.
`default_nettype none

package crfp_pkg;

    // Frame position of the next byte
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_ADDR_H = 3'd1,
        PH_ADDR_L = 3'd2,
        PH_CMD    = 3'd3,
        PH_LEN    = 3'd4,
        PH_QUAL   = 3'd5,
        PH_DATA   = 3'd6,
        PH_CHK    = 3'd7
    } phase_t;

    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_BAD_CK = 1'b1;

    // Result payload, listed from the top bit of tdata down
    typedef struct packed {
        logic [3:0]  pad;
        logic [3:0]  decimal_exponent;
        logic [15:0] raw_value;
        logic [7:0]  command_code;
        logic [15:0] device_address;
    } result_data_t;

    localparam int unsigned RESULT_W = $bits(result_data_t);

endpackage

`default_nettype wire

@@ rtl/chiller_response_frame_parser.sv @@
// Chiller response frame parser: byte stream in, one result per frame out.
// Slave stream s_* carries one received byte per transfer; master stream m_* carries
// the parsed frame. cfg_* writes the lead byte (reset 0xCA).
// A frame is lead, address high, address low, command, length, then "length" bytes
// (qualifier first, then data), then a checksum equal to the inverted low byte of the
// sum of all bytes after the lead. Bytes outside a frame other than the lead are dropped.
// Every byte is taken by a single-byte state update; s_tready stays high
// while the result register is empty or being drained, so one byte per cycle is
// sustained. The result appears on m_* in the cycle after the checksum byte's transfer
// and holds while m_tready is low; a new byte is then taken only once the result moves.
// m_tuser is the status (0 checksum matched, 1 mismatch).
// Reset returns the parser to idle, empties the result register and restores the lead
// byte. Write the lead byte only while no frame is in progress.
`default_nettype none

module chiller_response_frame_parser
    import crfp_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // configuration
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [7:0]          cfg_data,      // lead_byte
    // byte stream in
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [7:0]          s_tdata,       // rx_byte
    // result stream out
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [RESULT_W-1:0]      m_tdata,       // device_address[15:0], command_code[23:16],
                                                    // raw_value[39:24], decimal_exponent[43:40]
    output logic                     m_tuser        // status
);

    phase_t       phase_reg, phase_next;
    logic [7:0]   lead_reg;
    logic [7:0]   sum_reg, sum_next;
    logic [7:0]   left_reg, left_next;
    logic [15:0]  addr_reg, addr_next;
    logic [7:0]   cmd_reg, cmd_next;
    logic [15:0]  value_reg, value_next;
    logic [3:0]   exp_reg, exp_next;

    logic         out_valid_reg, out_valid_next;
    result_data_t out_data_reg, out_data_next;
    logic         out_status_reg, out_status_next;

    logic         in_xfer;
    logic [7:0]   left_dec;

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_xfer   = s_tvalid && s_tready;
    assign left_dec  = left_reg - 8'd1;

    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_status_reg;

    always_comb
    begin
        phase_next      = phase_reg;
        sum_next        = sum_reg;
        left_next       = left_reg;
        addr_next       = addr_reg;
        cmd_next        = cmd_reg;
        value_next      = value_reg;
        exp_next        = exp_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;

        if (in_xfer)
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (s_tdata == lead_reg)
                    begin
                        sum_next   = '0;
                        left_next  = '0;
                        addr_next  = '0;
                        cmd_next   = '0;
                        value_next = '0;
                        exp_next   = '0;
                        phase_next = PH_ADDR_H;
                    end
                end
                PH_ADDR_H:
                begin
                    sum_next   = sum_reg + s_tdata;
                    addr_next  = {s_tdata, 8'h00};
                    phase_next = PH_ADDR_L;
                end
                PH_ADDR_L:
                begin
                    sum_next   = sum_reg + s_tdata;
                    addr_next  = {addr_reg[15:8], s_tdata};
                    phase_next = PH_CMD;
                end
                PH_CMD:
                begin
                    sum_next   = sum_reg + s_tdata;
                    cmd_next   = s_tdata;
                    phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    sum_next   = sum_reg + s_tdata;
                    left_next  = s_tdata;
                    phase_next = (s_tdata == 8'd0) ? PH_CHK : PH_QUAL;
                end
                PH_QUAL:
                begin
                    sum_next   = sum_reg + s_tdata;
                    exp_next   = s_tdata[7:4];
                    left_next  = left_dec;
                    phase_next = (left_dec == 8'd0) ? PH_CHK : PH_DATA;
                end
                PH_DATA:
                begin
                    sum_next   = sum_reg + s_tdata;
                    value_next = {value_reg[7:0], s_tdata};
                    left_next  = left_dec;
                    if (left_dec == 8'd0)
                    begin
                        phase_next = PH_CHK;
                    end
                end
                PH_CHK:
                begin
                    // checksum is the inverted running sum
                    out_valid_next  = 1'b1;
                    out_status_next = (s_tdata == ~sum_reg) ? STATUS_OK : STATUS_BAD_CK;
                    out_data_next.pad              = '0;
                    out_data_next.decimal_exponent = exp_reg;
                    out_data_next.raw_value        = value_reg;
                    out_data_next.command_code     = cmd_reg;
                    out_data_next.device_address   = addr_reg;
                    sum_next   = '0;
                    left_next  = '0;
                    phase_next = PH_IDLE;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            lead_reg      <= 8'hCA;
            sum_reg       <= '0;
            left_reg      <= '0;
            addr_reg      <= '0;
            cmd_reg       <= '0;
            value_reg     <= '0;
            exp_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            sum_reg       <= sum_next;
            left_reg      <= left_next;
            addr_reg      <= addr_next;
            cmd_reg       <= cmd_next;
            value_reg     <= value_next;
            exp_reg       <= exp_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                lead_reg <= cfg_data;
            end
        end
    end

    // result payload, no reset
    always_ff @(posedge clk)
    begin
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
    end

endmodule

`default_nettype wire

@@ sim/chiller_response_frame_parser_tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for chiller_response_frame_parser: framed byte streams in, each
// parsed frame predicted in a scoreboard class and compared on the result stream.
// Depends on crfp_pkg and the parser RTL only.

module chiller_response_frame_parser_tb
    import crfp_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int PHASE_BYTES    = 340;
    localparam int LONG_HOLD      = 500;

    typedef logic [7:0] byte_q_t[$];

    typedef struct packed {
        logic        status;
        logic [15:0] device_address;
        logic [7:0]  command_code;
        logic [15:0] raw_value;
        logic [3:0]  decimal_exponent;
    } frame_result_t;

    class frame_scoreboard;
        logic [7:0]    lead;
        phase_t        phase;
        logic [7:0]    csum;
        logic [7:0]    remaining;
        logic [15:0]   addr;
        logic [7:0]    cmd;
        logic [15:0]   value;
        logic [3:0]    expo;
        frame_result_t parsed_frames[$];
        int            errors;

        function new();
            lead      = 8'hCA;
            phase     = PH_IDLE;
            csum      = '0;
            remaining = '0;
            addr      = '0;
            cmd       = '0;
            value     = '0;
            expo      = '0;
            errors    = 0;
        endfunction

        // Note one accepted byte; returns 0 when the parser simply drops it
        function bit parse_byte(logic [7:0] b);
            frame_result_t r;
            if (phase == PH_IDLE)
            begin
                if (b != lead)
                    return 1'b0;
                csum      = '0;
                remaining = '0;
                addr      = '0;
                cmd       = '0;
                value     = '0;
                expo      = '0;
                phase     = PH_ADDR_H;
                return 1'b1;
            end
            if (phase != PH_CHK)
                csum = csum + b;
            case (phase)
                PH_ADDR_H:
                begin
                    addr  = {b, 8'h00};
                    phase = PH_ADDR_L;
                end
                PH_ADDR_L:
                begin
                    addr[7:0] = b;
                    phase     = PH_CMD;
                end
                PH_CMD:
                begin
                    cmd   = b;
                    phase = PH_LEN;
                end
                PH_LEN:
                begin
                    remaining = b;
                    phase     = (b == 8'h00) ? PH_CHK : PH_QUAL;
                end
                PH_QUAL:
                begin
                    expo      = b[7:4];
                    remaining = remaining - 8'd1;
                    phase     = (remaining == 8'h00) ? PH_CHK : PH_DATA;
                end
                PH_DATA:
                begin
                    value     = {value[7:0], b};
                    remaining = remaining - 8'd1;
                    if (remaining == 8'h00)
                        phase = PH_CHK;
                end
                default:
                begin
                    r.status           = (b == ~csum) ? STATUS_OK : STATUS_BAD_CK;
                    r.device_address   = addr;
                    r.command_code     = cmd;
                    r.raw_value        = value;
                    r.decimal_exponent = expo;
                    parsed_frames      = {parsed_frames, r};
                    phase     = PH_IDLE;
                    csum      = '0;
                    remaining = '0;
                end
            endcase
            return 1'b1;
        endfunction

        function void compare(string field, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $error("%s: expected 0x%0h actual 0x%0h", field, want, got);
                errors++;
            end
        endfunction

        function void check_frame(logic [RESULT_W-1:0] data, logic status);
            result_data_t  got;
            frame_result_t want;
            got = result_data_t'(data);
            if (parsed_frames.size() == 0)
            begin
                $error("unexpected frame: address 0x%0h command 0x%0h",
                       got.device_address, got.command_code);
                errors++;
                return;
            end
            want = parsed_frames.pop_front();
            compare("status", 16'(want.status), 16'(status));
            compare("device_address", want.device_address, got.device_address);
            compare("command_code", 16'(want.command_code), 16'(got.command_code));
            compare("raw_value", want.raw_value, got.raw_value);
            compare("decimal_exponent", 16'(want.decimal_exponent),
                    16'(got.decimal_exponent));
        endfunction
    endclass

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_valid = 1'b0;
    logic [7:0]          cfg_data  = 8'h00;
    logic                s_tvalid  = 1'b0;
    logic [7:0]          s_tdata   = 8'h00;
    logic                m_tready  = 1'b0;
    logic                cfg_ready;
    logic                s_tready;
    logic                m_tvalid;
    logic [RESULT_W-1:0] m_tdata;
    logic                m_tuser;

    frame_scoreboard board;
    bit              quiet = 1'b0;
    int              hold_cycles = 0;
    int              consumed_bytes = 0;
    int              idle_cycles = 0;

    chiller_response_frame_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 clk = ~clk;

    // Offer one byte, idling at random first, and hold it until the transfer
    task automatic send_byte(input logic [7:0] b);
        while (!quiet && $urandom_range(99) < 38)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        if (board.parse_byte(b))
            consumed_bytes++;
    endtask

    task automatic send_frame(input byte_q_t body, input bit bad);
        logic [7:0] sum;
        logic [7:0] chk;
        sum = '0;
        send_byte(board.lead);
        foreach (body[i])
        begin
            sum = sum + body[i];
            send_byte(body[i]);
        end
        chk = ~sum;
        if (bad)
            chk = chk ^ 8'($urandom_range(255, 1));
        send_byte(chk);
    endtask

    // Address, command, length and payload; mostly short frames, a few long ones
    function automatic byte_q_t random_body();
        byte_q_t body;
        int      len;
        int      pick;
        pick = $urandom_range(99);
        if (pick < 70)
            len = $urandom_range(6);
        else if (pick < 97)
            len = $urandom_range(20, 7);
        else
            len = $urandom_range(255, 21);
        body = {};
        repeat (3)
            body = {body, 8'($urandom)};
        body = {body, 8'(len)};
        repeat (len)
            body = {body, 8'($urandom)};
        return body;
    endfunction

    task automatic random_traffic(input int target);
        byte_q_t body;
        int      stop_at;
        int      pick;
        int      cut;
        stop_at = consumed_bytes + target;
        while (consumed_bytes < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
            begin
                repeat ($urandom_range(4, 1))
                    send_byte(8'($urandom));
            end
            else if (pick < 15)
            begin
                // truncated frame: whatever follows is swallowed as frame bytes
                body = random_body();
                cut  = $urandom_range(body.size() - 1);
                send_byte(board.lead);
                for (int i = 0; i < cut; i++)
                    send_byte(body[i]);
            end
            else
                send_frame(random_body(), $urandom_range(99) < 15);
        end
    endtask

    // Run the parser back to idle so the lead byte may be changed
    task automatic finish_frame();
        while (board.phase != PH_IDLE)
            send_byte(8'($urandom));
    endtask

    task automatic write_lead(input logic [7:0] v);
        s_tvalid <= 1'b0;
        while (board.parsed_frames.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.lead = v;
    endtask

    // Result side: check each transfer, then choose the next ready level
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                board.check_frame(m_tdata, m_tuser);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= quiet || ($urandom_range(99) >= 38);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** chiller_response_frame_parser: FAILED **");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        byte_q_t    body;
        logic [7:0] next_lead;
        board = new();
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;

        // idle bytes, then zero length, qualifier only with a bad checksum,
        // and lead values inside a frame with more data than the value holds
        send_byte(8'h00);
        send_byte(8'hFF);
        body = {8'hFF, 8'hFF, 8'hFF, 8'h00};
        send_frame(body, 1'b0);
        body = {8'h00, 8'h00, 8'h00, 8'h01, 8'hF0};
        send_frame(body, 1'b1);
        body = {8'hCA, 8'hCA, 8'h5A, 8'h04, 8'h3C, 8'hCA, 8'h81, 8'hFF};
        send_frame(body, 1'b0);

        for (int p = 0; p < 6; p++)
        begin
            case (p)
                1:       next_lead = 8'h00;
                2:       next_lead = 8'hFF;
                5:       next_lead = 8'hCA;
                default: next_lead = 8'($urandom);
            endcase
            if (p > 0)
                write_lead(next_lead);
            // stall the result side for a long stretch so the input backs up
            if (p == 2)
                hold_cycles = LONG_HOLD;
            quiet = (p == 3);
            random_traffic(PHASE_BYTES);
            finish_frame();
        end

        quiet = 1'b0;
        s_tvalid <= 1'b0;
        while (board.parsed_frames.size() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
        if (board.errors == 0)
            $display("** chiller_response_frame_parser: PASSED **");
        else
            $display("** chiller_response_frame_parser: FAILED **");
        $finish;
    end

endmodule

@@ chiller_response_frame_parser.f @@
rtl/crfp_pkg.sv
rtl/chiller_response_frame_parser.sv
sim/chiller_response_frame_parser_tb.sv
